@@ src/aarch64_relocation_patcher_top_defines.svh @@
// Assertion macros for the relocation patcher top level.
// Used by aarch64_relocation_patcher_top.sv; expects clk and rst_n in scope.
`ifndef AARCH64_RELOCATION_PATCHER_TOP_DEFINES_SVH
`define AARCH64_RELOCATION_PATCHER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define ARP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define ARP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/arp_pkg.sv @@
// Shared types and constants of the AArch64 relocation patcher.
// No dependencies; imported by arp_addr, arp_encode and the top level.
package arp_pkg;

    // Configuration register indexes
    localparam logic [7:0] CFG_VIRT_OFFSET = 8'd0;
    localparam logic [7:0] CFG_EXEC_MODE   = 8'd1;

    // Symbol kinds
    localparam logic [2:0] KIND_SECTION = 3'd0;
    localparam logic [2:0] KIND_UNDEF   = 3'd1;
    localparam logic [2:0] KIND_COMMON  = 3'd2;
    localparam logic [2:0] KIND_ABS     = 3'd3;
    localparam logic [2:0] KIND_SYSBASE = 3'd4;

    // Address the system base symbol resolves to
    localparam logic [63:0] SYSBASE_ADDR = 64'd4;

    // ABI relocation types
    localparam logic [15:0] R_NONE              = 16'd0;
    localparam logic [15:0] R_ABS64             = 16'd257;
    localparam logic [15:0] R_ABS32             = 16'd258;
    localparam logic [15:0] R_PREL64            = 16'd260;
    localparam logic [15:0] R_PREL32            = 16'd261;
    localparam logic [15:0] R_MOVW_UABS_G0      = 16'd263;
    localparam logic [15:0] R_MOVW_UABS_G0_NC   = 16'd264;
    localparam logic [15:0] R_MOVW_UABS_G1      = 16'd265;
    localparam logic [15:0] R_MOVW_UABS_G1_NC   = 16'd266;
    localparam logic [15:0] R_MOVW_UABS_G2      = 16'd267;
    localparam logic [15:0] R_MOVW_UABS_G2_NC   = 16'd268;
    localparam logic [15:0] R_MOVW_UABS_G3      = 16'd269;
    localparam logic [15:0] R_LD_PREL_LO19      = 16'd273;
    localparam logic [15:0] R_ADR_PREL_LO21     = 16'd274;
    localparam logic [15:0] R_ADR_PREL_PG_HI21  = 16'd275;
    localparam logic [15:0] R_ADR_PREL_PG_HI21N = 16'd276;
    localparam logic [15:0] R_ADD_ABS_LO12_NC   = 16'd277;
    localparam logic [15:0] R_LDST8_LO12_NC     = 16'd278;
    localparam logic [15:0] R_TSTBR14           = 16'd279;
    localparam logic [15:0] R_CONDBR19          = 16'd280;
    localparam logic [15:0] R_JUMP26            = 16'd282;
    localparam logic [15:0] R_CALL26            = 16'd283;
    localparam logic [15:0] R_LDST16_LO12_NC    = 16'd284;
    localparam logic [15:0] R_LDST32_LO12_NC    = 16'd285;
    localparam logic [15:0] R_LDST64_LO12_NC    = 16'd286;
    localparam logic [15:0] R_LDST128_LO12_NC   = 16'd299;
    localparam logic [15:0] R_ADR_GOT_PAGE      = 16'd311;
    localparam logic [15:0] R_LD64_GOT_LO12_NC  = 16'd312;

    typedef enum logic [2:0] {
        ST_PATCHED = 3'd0,
        ST_NOP     = 3'd1,
        ST_UNDEF   = 3'd2,
        ST_COMMON  = 3'd3,
        ST_UNKNOWN = 3'd4
    } arp_status_t;

    typedef enum logic [1:0] {
        WB_NONE = 2'd0,
        WB_W4   = 2'd1,
        WB_W8   = 2'd2
    } arp_wbytes_t;

    // One captured request
    typedef struct packed {
        logic [15:0] cmd;
        logic [63:0] old_word;
        logic [63:0] sym_value;
        logic [63:0] addend;
        logic [63:0] place_addr;
        logic [2:0]  sym_kind;
        logic [63:0] sym_sec_load;
        logic [63:0] sym_sec_link;
        logic [63:0] tgt_sec_load;
        logic [63:0] tgt_sec_link;
        logic        same_section;
    } arp_req_t;

    // Resolved addresses handed from the address stage to the encoder
    typedef struct packed {
        logic [15:0] cmd;
        logic [2:0]  sym_kind;
        logic        same_section;
        logic [63:0] old_word;
        logic [63:0] tgt;      // S + A + virtual offset
        logic [63:0] tgtx;     // target as used by the low-12, MOVW and GOT forms
        logic [63:0] rel;      // S + A - P
        logic [63:0] pv;       // P + virtual offset
        logic [63:0] move;     // section displacement, symbol vs. target
        logic [63:0] shifted;  // old word + section displacement + virtual offset
    } arp_mid_t;

    typedef struct packed {
        logic [63:0] new_word;
        arp_wbytes_t write_bytes;
        arp_status_t status;
    } arp_res_t;

endpackage

@@ src/aarch64_relocation_patcher_top.sv @@
// Top level of the AArch64 RELA relocation patcher: request capture, address
// stage, encoder stage, result register. Depends on arp_pkg, arp_addr,
// arp_encode and aarch64_relocation_patcher_top_defines.svh.
//
//   channel | handshake             | payload
//   --------+-----------------------+---------------------------------------
//   request | req_valid / req_stall | cmd .. same_section
//   result  | res_valid / res_stall | new_word, write_bytes, status
//   config  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request per cycle sustained while the result channel is not stalled; a
// request passes through the request, address and result registers before
// res_valid rises.
// A stalled result holds the whole pipeline only once all three stages are full.
// Reset clears the stage valid bits and both configuration registers.
// cfg_ready is always high; writes take effect on the next cycle.
`include "aarch64_relocation_patcher_top_defines.svh"

module aarch64_relocation_patcher_top import arp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [15:0]        cmd,
    input  logic [63:0]        old_word,
    input  logic [63:0]        sym_value,
    input  logic signed [63:0] addend,
    input  logic [63:0]        place_addr,
    input  logic [2:0]         sym_kind,
    input  logic [63:0]        sym_sec_load,
    input  logic [63:0]        sym_sec_link,
    input  logic [63:0]        tgt_sec_load,
    input  logic [63:0]        tgt_sec_link,
    input  logic               same_section,
    // result channel
    output logic               res_valid,
    input  logic               res_stall,
    output logic [63:0]        new_word,
    output logic [1:0]         write_bytes,
    output logic [2:0]         status,
    // configuration channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    logic        req_v_reg;
    logic        req_v_next;
    logic        mid_v_reg;
    logic        mid_v_next;
    logic        res_v_reg;
    logic        res_v_next;
    arp_req_t    req_q_reg;
    arp_mid_t    mid_q_reg;
    arp_res_t    res_q_reg;
    logic [63:0] virt_offset_reg;
    logic        exec_mode_reg;

    logic        adv_req;
    logic        adv_mid;
    logic        adv_res;
    arp_req_t    req_in;
    arp_mid_t    mid_d;
    arp_res_t    res_d;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            virt_offset_reg <= '0;
            exec_mode_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_VIRT_OFFSET)
            begin
                virt_offset_reg <= cfg_data;
            end
            else if (cfg_index == CFG_EXEC_MODE)
            begin
                exec_mode_reg <= cfg_data[0];
            end
        end
    end

    // Stage advance: a stage moves when it is empty or its successor moves
    assign adv_res   = !res_v_reg || !res_stall;
    assign adv_mid   = !mid_v_reg || adv_res;
    assign adv_req   = !req_v_reg || adv_mid;
    assign req_stall = !adv_req;

    assign req_v_next = adv_req ? req_valid : req_v_reg;
    assign mid_v_next = adv_mid ? req_v_reg : mid_v_reg;
    assign res_v_next = adv_res ? mid_v_reg : res_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_v_reg <= 1'b0;
            mid_v_reg <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            req_v_reg <= req_v_next;
            mid_v_reg <= mid_v_next;
            res_v_reg <= res_v_next;
        end
    end

    // Request capture
    always_comb
    begin
        req_in.cmd          = cmd;
        req_in.old_word     = old_word;
        req_in.sym_value    = sym_value;
        req_in.addend       = $unsigned(addend);
        req_in.place_addr   = place_addr;
        req_in.sym_kind     = sym_kind;
        req_in.sym_sec_load = sym_sec_load;
        req_in.sym_sec_link = sym_sec_link;
        req_in.tgt_sec_load = tgt_sec_load;
        req_in.tgt_sec_link = tgt_sec_link;
        req_in.same_section = same_section;
    end

    // Datapath registers, loaded only when the stage advances with data
    always_ff @(posedge clk)
    begin
        if (adv_req && req_valid)
        begin
            req_q_reg <= req_in;
        end
        if (adv_mid && req_v_reg)
        begin
            mid_q_reg <= mid_d;
        end
        if (adv_res && mid_v_reg)
        begin
            res_q_reg <= res_d;
        end
    end

    arp_addr u_addr
    (
        .req         (req_q_reg),
        .virt_offset (virt_offset_reg),
        .exec_mode   (exec_mode_reg),
        .mid         (mid_d)
    );

    arp_encode u_encode
    (
        .mid       (mid_q_reg),
        .exec_mode (exec_mode_reg),
        .res       (res_d)
    );

    // Result channel
    assign res_valid   = res_v_reg;
    assign new_word    = res_q_reg.new_word;
    assign write_bytes = res_q_reg.write_bytes;
    assign status      = res_q_reg.status;

    // Checks
    `ARP_ASSERT_NOW(a_wb_code, res_valid,
        (write_bytes == WB_NONE || write_bytes == WB_W4 || write_bytes == WB_W8),
        "write_bytes outside its codes")
    `ARP_ASSERT_NOW(a_write_iff_patched, res_valid,
        ((write_bytes == WB_NONE) == (status != ST_PATCHED)),
        "write size disagrees with status")
    `ARP_ASSERT_NOW(a_w4_upper_zero, (res_valid && write_bytes == WB_W4),
        (new_word[63:32] == 32'd0), "4-byte result has upper bits set")
    `ARP_ASSERT_NOW(a_stall_only_full, req_stall,
        (req_v_reg && mid_v_reg && res_v_reg && res_stall),
        "request stalled with room in pipeline")
    `ARP_ASSERT_NEXT(a_take_fills, (req_valid && !req_stall), req_v_reg,
        "accepted request not held in request register")

endmodule

@@ src/arp_addr.sv @@
// Address stage: forms the symbol address and all wide sums of one request.
// Depends on arp_pkg.
module arp_addr import arp_pkg::*;
(
    input  arp_req_t    req,
    input  logic [63:0] virt_offset,
    input  logic        exec_mode,
    output arp_mid_t    mid
);

    logic        is_abs;
    logic        is_sb;
    logic [63:0] sl_e;
    logic [63:0] sk_e;
    logic [63:0] vo_e;
    logic [63:0] full_tgt;
    logic [63:0] tgt;

    // Absolute kinds ignore the section terms; system base drops the offset too
    assign is_abs = (req.sym_kind == KIND_ABS) || (req.sym_kind == KIND_SYSBASE);
    assign is_sb  = (req.sym_kind == KIND_SYSBASE);
    assign sl_e   = is_abs ? '0 : req.sym_sec_load;
    assign sk_e   = is_abs ? '0 : req.sym_sec_link;
    assign vo_e   = is_sb  ? '0 : virt_offset;

    // Multi-operand sums, one adder tree each
    assign full_tgt = sl_e - sk_e + req.sym_value + req.addend + vo_e;
    assign tgt      = is_sb ? (SYSBASE_ADDR + req.addend) : full_tgt;

    always_comb
    begin
        mid.cmd          = req.cmd;
        mid.sym_kind     = req.sym_kind;
        mid.same_section = req.same_section;
        mid.old_word     = req.old_word;
        mid.tgt          = tgt;
        mid.tgtx         = (is_sb && exec_mode) ? (req.sym_value + req.addend) : tgt;
        mid.rel          = is_sb ? (SYSBASE_ADDR + req.addend - req.place_addr)
                                 : (sl_e - sk_e + req.sym_value + req.addend
                                    - req.place_addr);
        mid.pv           = req.place_addr + vo_e;
        mid.move         = sl_e - req.tgt_sec_load - sk_e + req.tgt_sec_link;
        mid.shifted      = req.old_word + sl_e - sk_e + vo_e;
    end

endmodule

@@ src/arp_encode.sv @@
// Encoder stage: picks the relocation form and inserts the immediate fields.
// Depends on arp_pkg; only narrow adds here, the wide sums come from arp_addr.
module arp_encode import arp_pkg::*;
(
    input  arp_mid_t mid,
    input  logic     exec_mode,
    output arp_res_t res
);

    // ADR/ADRP immediate: immlo at [30:29], immhi at [23:5]
    function automatic logic [31:0] adr_ins(input logic [31:0] ow, input logic [20:0] off);
        adr_ins = (ow & 32'h9F00001F) | {1'b0, off[1:0], 5'd0, off[20:2], 5'd0};
    endfunction

    logic [31:0] ow;
    logic [20:0] pg;
    logic [20:0] pgx;
    logic [20:0] adr_off;
    logic [25:0] b26;
    logic [18:0] b19;
    logic [13:0] b14;
    logic [2:0]  lsh;
    logic [11:0] lo12;
    logic [15:0] mw;
    logic [31:0] r;
    logic        skip;
    logic        w32;
    logic        w64;
    logic        ex_same;

    assign ow      = mid.old_word[31:0];
    assign ex_same = exec_mode && mid.same_section;

    // Page and low-21 offsets only need the bits that land in the field
    assign pg      = mid.tgt[32:12]  - mid.pv[32:12];
    assign pgx     = mid.tgtx[32:12] - mid.pv[32:12];
    assign adr_off = mid.tgt[20:0]   - mid.pv[20:0];

    // Branch offsets: linked words move by the displacement, objects take S+A-P
    assign b26 = exec_mode ? (ow[25:0] + mid.move[27:2]) : mid.rel[27:2];
    assign b19 = exec_mode ? (ow[23:5] + mid.move[20:2]) : mid.rel[20:2];
    assign b14 = exec_mode ? (ow[18:5] + mid.move[15:2]) : mid.rel[15:2];

    // Load/store scale for the low-12 forms
    always_comb
    begin
        case (mid.cmd)
            R_LDST16_LO12_NC:  lsh = 3'd1;
            R_LDST32_LO12_NC:  lsh = 3'd2;
            R_LDST64_LO12_NC:  lsh = 3'd3;
            R_LDST128_LO12_NC: lsh = 3'd4;
            default:           lsh = 3'd0;
        endcase
    end
    assign lo12 = mid.tgtx[11:0] >> lsh;

    // MOVW halfword select
    always_comb
    begin
        case (mid.cmd)
            R_MOVW_UABS_G1, R_MOVW_UABS_G1_NC: mw = mid.tgtx[31:16];
            R_MOVW_UABS_G2, R_MOVW_UABS_G2_NC: mw = mid.tgtx[47:32];
            R_MOVW_UABS_G3:                    mw = mid.tgtx[63:48];
            default:                           mw = mid.tgtx[15:0];
        endcase
    end

    // Form select and result
    always_comb
    begin
        r               = '0;
        skip            = 1'b0;
        w32             = 1'b0;
        w64             = 1'b0;
        res.new_word    = mid.old_word;
        res.write_bytes = WB_NONE;
        res.status      = ST_PATCHED;
        if (mid.cmd == R_NONE)
        begin
            res.status = ST_NOP;
        end
        else if (mid.sym_kind == KIND_UNDEF)
        begin
            res.status = ST_UNDEF;
        end
        else if (mid.sym_kind == KIND_COMMON)
        begin
            res.status = ST_COMMON;
        end
        else
        begin
            w32 = 1'b1;
            case (mid.cmd)
                R_ABS64:
                begin
                    w32 = 1'b0;
                    w64 = 1'b1;
                    res.new_word = exec_mode ? mid.shifted : mid.tgt;
                end
                R_ABS32:
                    r = exec_mode ? mid.shifted[31:0] : mid.tgt[31:0];
                R_PREL64:
                begin
                    w32 = 1'b0;
                    w64 = 1'b1;
                    res.new_word = mid.rel;
                end
                R_PREL32:
                begin
                    skip = ex_same;
                    r    = exec_mode ? (ow + mid.move[31:0]) : mid.rel[31:0];
                end
                R_JUMP26, R_CALL26:
                begin
                    skip = ex_same;
                    r    = {ow[31:26], b26};
                end
                R_ADR_PREL_PG_HI21, R_ADR_PREL_PG_HI21N:
                begin
                    skip = ex_same;
                    r    = adr_ins(ow, pg);
                end
                R_ADR_PREL_LO21:
                begin
                    skip = ex_same;
                    r    = adr_ins(ow, adr_off);
                end
                R_ADD_ABS_LO12_NC, R_LDST8_LO12_NC, R_LDST16_LO12_NC,
                R_LDST32_LO12_NC, R_LDST64_LO12_NC, R_LDST128_LO12_NC:
                    r = {ow[31:22], lo12, ow[9:0]};
                R_MOVW_UABS_G0, R_MOVW_UABS_G0_NC, R_MOVW_UABS_G1, R_MOVW_UABS_G1_NC,
                R_MOVW_UABS_G2, R_MOVW_UABS_G2_NC, R_MOVW_UABS_G3:
                    r = {ow[31:21], mw, ow[4:0]};
                R_LD_PREL_LO19, R_CONDBR19:
                begin
                    skip = ex_same;
                    r    = {ow[31:24], b19, ow[4:0]};
                end
                R_TSTBR14:
                begin
                    skip = ex_same;
                    r    = {ow[31:19], b14, ow[4:0]};
                end
                R_ADR_GOT_PAGE:
                    r = adr_ins(ow, pgx);
                R_LD64_GOT_LO12_NC:
                    // GOT load relaxed to ADD Xd, Xn, #lo12
                    r = 32'h91000000 | {10'd0, mid.tgtx[11:0], ow[9:0]};
                default:
                begin
                    w32        = 1'b0;
                    res.status = ST_UNKNOWN;
                end
            endcase
            if (skip)
            begin
                res.status = ST_NOP;
            end
            else if (w32)
            begin
                res.new_word    = {32'd0, r};
                res.write_bytes = WB_W4;
            end
            else if (w64)
            begin
                res.write_bytes = WB_W8;
            end
        end
    end

endmodule
